>>> design/utvt_pkg.sv
// Shared types and constants for the UTF-8 text validator and transcoder.
// No dependencies; imported by every module of the block.
package utvt_pkg;

	// Status codes carried on the final status result
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_MALFORMED  = 3'd1;
	localparam logic [2:0] ST_CONTROL    = 3'd2;
	localparam logic [2:0] ST_NOT_LATIN1 = 3'd3;
	localparam logic [2:0] ST_TOO_LONG   = 3'd4;

	// Configuration register indexes
	localparam logic REG_LATIN1_MODE = 1'b0;
	localparam logic REG_TEXT_LIMIT  = 1'b1;

	localparam logic [6:0] TEXT_LIMIT_RST = 7'd127;

	// Lead byte ranges
	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	// Code point limits
	localparam logic [20:0] CP_MIN2       = 21'h000080;
	localparam logic [20:0] CP_MIN3       = 21'h000800;
	localparam logic [20:0] CP_MIN4       = 21'h010000;
	localparam logic [20:0] CP_MAX        = 21'h10FFFF;
	localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] CP_SPACE      = 21'h000020;
	localparam logic [20:0] CP_DEL        = 21'h00007F;
	localparam logic [20:0] CP_LATIN1_MAX = 21'h0000FF;

	// Per-text decoder state
	typedef struct packed {
		logic [20:0] code_accum;
		logic [1:0]  bytes_pending;
		logic [1:0]  seq_class;
		logic [6:0]  out_count;
		logic [2:0]  error_code;
	} text_state_t;

	// All results caused by one input byte
	typedef struct packed {
		logic [3:0][7:0] text;
		logic [2:0]      n_text;
		logic            has_status;
		logic [2:0]      status;
		logic [6:0]      cnt_base;
	} bundle_t;

endpackage

>>> design/utvt_decode.sv
// Combinational decode, validation and transcode of one input byte.
// Depends on utvt_pkg for the state and result bundle types.
module utvt_decode (
	input  utvt_pkg::text_state_t st_q,
	input  logic [2:0][7:0]       held,
	input  logic [7:0]            in_byte,
	input  logic                  end_of_text,
	input  logic                  latin1_mode,
	input  logic [6:0]            text_limit,
	output utvt_pkg::text_state_t st_d,
	output logic [2:0]            held_we,
	output utvt_pkg::bundle_t     bundle
);
	import utvt_pkg::*;

	always_comb begin
		logic [20:0]     cp;
		logic [20:0]     accum_n;
		logic [20:0]     cp_min;
		logic            complete;
		logic            emit;
		logic [2:0]      n;
		logic [3:0][7:0] text;
		logic [2:0]      err_n;
		logic [1:0]      held_idx;
		logic [7:0]      sum;

		st_d     = st_q;
		held_we  = '0;
		cp       = '0;
		accum_n  = '0;
		complete = 1'b0;
		emit     = 1'b0;
		n        = 3'd0;
		text     = '0;
		err_n    = st_q.error_code;
		held_idx = 2'(st_q.seq_class + 2'd1 - st_q.bytes_pending);
		sum      = '0;

		case (st_q.seq_class)
			2'd1:    cp_min = CP_MIN2;
			2'd2:    cp_min = CP_MIN3;
			default: cp_min = CP_MIN4;
		endcase

		if (st_q.error_code == ST_OK) begin
			// Lead byte or continuation byte
			if (st_q.bytes_pending == 2'd0) begin
				if (!in_byte[7]) begin
					st_d.seq_class = 2'd0;
					complete       = 1'b1;
					cp             = {13'd0, in_byte};
				end else if (in_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
					st_d.seq_class     = 2'd1;
					st_d.bytes_pending = 2'd1;
					st_d.code_accum    = {16'd0, in_byte[4:0]};
					held_we            = 3'b001;
				end else if (in_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
					st_d.seq_class     = 2'd2;
					st_d.bytes_pending = 2'd2;
					st_d.code_accum    = {17'd0, in_byte[3:0]};
					held_we            = 3'b001;
				end else if (in_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
					st_d.seq_class     = 2'd3;
					st_d.bytes_pending = 2'd3;
					st_d.code_accum    = {18'd0, in_byte[2:0]};
					held_we            = 3'b001;
				end else begin
					err_n = ST_MALFORMED;
				end
			end else if ((in_byte & CONT_MASK) != CONT_TAG) begin
				err_n = ST_MALFORMED;
			end else begin
				accum_n            = {st_q.code_accum[14:0], in_byte[5:0]};
				st_d.code_accum    = accum_n;
				st_d.bytes_pending = st_q.bytes_pending - 2'd1;
				if (st_q.bytes_pending > 2'd1) begin
					held_we[held_idx] = 1'b1;
				end
				// Last continuation: range checks on the full code point
				if (st_q.bytes_pending == 2'd1) begin
					cp = accum_n;
					if (cp < cp_min || cp > CP_MAX ||
					    (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
						err_n = ST_MALFORMED;
					end else begin
						complete = 1'b1;
					end
				end
			end

			// Completed code point: reject controls and non-Latin-1 code points, build output bytes
			if (complete) begin
				if (cp < CP_SPACE || cp == CP_DEL) begin
					err_n = ST_CONTROL;
				end else if (latin1_mode && cp > CP_LATIN1_MAX) begin
					err_n = ST_NOT_LATIN1;
				end else begin
					if (latin1_mode) begin
						text[0] = cp[7:0];
						n       = 3'd1;
					end else begin
						case (st_d.seq_class)
							2'd0: begin
								text[0] = in_byte;
								n       = 3'd1;
							end
							2'd1: begin
								text[0] = held[0];
								text[1] = in_byte;
								n       = 3'd2;
							end
							2'd2: begin
								text[0] = held[0];
								text[1] = held[1];
								text[2] = in_byte;
								n       = 3'd3;
							end
							default: begin
								text[0] = held[0];
								text[1] = held[1];
								text[2] = held[2];
								text[3] = in_byte;
								n       = 3'd4;
							end
						endcase
					end
					// Length check against the limit
					sum = {1'b0, st_q.out_count} + {5'd0, n};
					if (sum > {1'b0, text_limit}) begin
						err_n = ST_TOO_LONG;
					end else begin
						emit           = 1'b1;
						st_d.out_count = sum[6:0];
					end
				end
			end

			// Truncated sequence at end of text
			if (end_of_text && err_n == ST_OK && st_d.bytes_pending != 2'd0) begin
				err_n = ST_MALFORMED;
			end
		end

		st_d.error_code = err_n;

		bundle.text       = text;
		bundle.n_text     = emit ? n : 3'd0;
		bundle.has_status = end_of_text;
		bundle.status     = err_n;
		bundle.cnt_base   = st_q.out_count;

		// Clear per-text state after the status result
		if (end_of_text) begin
			st_d = '0;
		end
	end

endmodule

>>> design/utvt_emit.sv
// Result register and serializer: holds one byte's results and sends them
// one per cycle while out_stall is low. Depends on utvt_pkg for the bundle type.
module utvt_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  utvt_pkg::bundle_t bundle,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              is_status,
	output logic [2:0]        status,
	output logic [6:0]        byte_count,
	output logic              final_res
);
	import utvt_pkg::*;

	bundle_t    bnd_q;
	logic       valid_q;
	logic [2:0] idx_q;
	logic [2:0] total;
	logic [2:0] new_total;
	logic       last_res;
	logic       is_text;

	assign total     = bnd_q.n_text + {2'd0, bnd_q.has_status};
	assign new_total = bundle.n_text + {2'd0, bundle.has_status};
	assign last_res  = (idx_q == total - 3'd1);
	assign can_load  = !valid_q || (last_res && !out_stall);

	// Hold the payload of the current bundle
	always_ff @(posedge clk) begin
		if (load && new_total != 3'd0) begin
			bnd_q <= bundle;
		end
	end

	// Advance through the results, reload when the last one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= (new_total != 3'd0);
			idx_q   <= 3'd0;
		end else if (valid_q && !out_stall) begin
			if (last_res) begin
				valid_q <= 1'b0;
				idx_q   <= 3'd0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Select the current result
	assign is_text    = (idx_q < bnd_q.n_text);
	assign out_valid  = valid_q;
	assign out_byte   = is_text ? bnd_q.text[idx_q[1:0]] : 8'd0;
	assign is_status  = !is_text;
	assign status     = is_text ? ST_OK : bnd_q.status;
	assign byte_count = is_text ? (bnd_q.cnt_base + {4'd0, idx_q} + 7'd1)
	                            : (bnd_q.cnt_base + {4'd0, bnd_q.n_text});
	assign final_res  = !is_text;

endmodule

>>> design/utf8_text_validate_transcode.sv
// UTF-8 text validator and Latin-1 transcoder, top level.
// Output: a byte's first result is registered and appears in the cycle after its transaction.
// Throughput: one byte per cycle while each byte yields at most one result and out_stall
// is low; a byte causing several results stalls input until its last result leaves the single output port.
// Reset: asynchronous, clears decoder state and sets latin1_mode 0, text_limit 127.
// Uses utvt_pkg, utvt_decode and utvt_emit.
module utf8_text_validate_transcode (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_status,
	output logic [2:0] status,
	output logic [6:0] byte_count,
	output logic       final_res
);
	import utvt_pkg::*;

	logic            latin1_mode_q;
	logic [6:0]      text_limit_q;
	text_state_t     st_q;
	text_state_t     st_d;
	logic [2:0][7:0] held_q;
	logic [2:0]      held_we;
	bundle_t         bundle;
	logic            can_load;
	logic            load;

	assign in_stall = !can_load;
	assign load     = in_valid && can_load;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latin1_mode_q <= 1'b0;
			text_limit_q  <= TEXT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LATIN1_MODE: latin1_mode_q <= cfg_wdata[0];
				REG_TEXT_LIMIT:  text_limit_q  <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// Decoder state, updated on each input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (load) begin
			st_q <= st_d;
		end
	end

	// Held sequence bytes for pass-through
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (load && held_we[i]) begin
				held_q[i] <= in_byte;
			end
		end
	end

	utvt_decode u_decode (
		.st_q        (st_q),
		.held        (held_q),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.latin1_mode (latin1_mode_q),
		.text_limit  (text_limit_q),
		.st_d        (st_d),
		.held_we     (held_we),
		.bundle      (bundle)
	);

	utvt_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.bundle     (bundle),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_status  (is_status),
		.status     (status),
		.byte_count (byte_count),
		.final_res  (final_res)
	);

`ifndef NO_ASSERTIONS
	// The last byte of a text always brings a result in the next cycle
	a_status_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && end_of_text) |=> out_valid)
		else $error("no result after end of text");

	// Input is only held back while results are waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no pending result");

	// A status result carries a zero byte and closes the text
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_status) |-> (final_res && out_byte == 8'd0))
		else $error("malformed status result");

	// Text bytes always report ok
	a_text_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_status) |-> (status == ST_OK && !final_res))
		else $error("text byte with nonzero status");
`endif

endmodule
